>>> rtl/indexed_min_heap_assert.svh
// Assertion macros for the indexed min-heap checker.
// Uses clk and rst from the scope where the macros are expanded.
`ifndef INDEXED_MIN_HEAP_ASSERT_SVH
`define INDEXED_MIN_HEAP_ASSERT_SVH

// Implication checked in the same cycle.
`define IMH_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("indexed_min_heap: same-cycle check failed");

// Implication checked in the next cycle.
`define IMH_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("indexed_min_heap: next-cycle check failed");

`endif

>>> rtl/imh_pkg.sv
// Types and constants shared by the indexed min-heap modules.
// No dependencies.
package imh_pkg;

  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef enum logic [1:0] {
    FN_RESTART  = 2'd0,
    FN_DECREASE = 2'd1,
    FN_EXTRACT  = 2'd2,
    FN_QUERY    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_LK_SLOT, S_LK_CHK, S_UP_P, S_UP_K, S_UP_C,
    S_EX_A, S_EX_B, S_EX_C, S_DN_L, S_DN_R, S_DN_K, S_DN_C, S_FIN
  } state_t;

endpackage

>>> rtl/imh_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module imh_ram #(
  parameter int DEPTH = 1024,
  parameter int AW = 10,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/indexed_min_heap.sv
// Indexed binary min-heap; one request at a time, one result per request.
// A restart fills one entry per vertex (vertex_count, capped at MAX_VERTICES); a query,
// an absent vertex or a larger-key decrease does only the lookup; otherwise a decrease
// rises level by level, and an extract sinks the last entry level by level. Each RAM has
// a single read port. The next request can be taken while the result is shown; a result
// waits while out_stall holds the previous one. Reset empties the heap, sets 1024.
module indexed_min_heap #(
  parameter int MAX_VERTICES = 1024,
  parameter int KEY_BITS = 31,
  localparam int VID_W = $clog2(MAX_VERTICES),
  localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [imh_pkg::CFG_W-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  imh_pkg::func_t         func,
  input  logic [VID_W-1:0]       vertex_id,
  input  logic [KEY_BITS-1:0]    new_key,
  output logic                   out_valid,
  input  logic                   out_stall,
  output imh_pkg::status_t       status,
  output logic [VID_W-1:0]       out_vertex,
  output logic [KEY_BITS-1:0]    out_key,
  output logic                   present,
  output logic [CNT_W-1:0]       heap_count
);
  import imh_pkg::*;

  state_t state, state_next;
  logic [CFG_W-1:0] vcount;
  logic [CNT_W-1:0] live, fill_n, idx, fill_sat;
  func_t op;
  logic [VID_W-1:0] vid, cur_slot, cur_v, p_v, l_v, r_v, best_v, parent, last;
  logic [KEY_BITS-1:0] key, old_key, cur_k, l_k, min_k;
  status_t res_status;
  logic [VID_W-1:0] res_vertex;
  logic [KEY_BITS-1:0] res_key;
  logic res_present;
  logic [VID_W+1:0] l_ext, r_ext, live_ext;
  logic l_in, r_in, lt_l, lt_r, live_ok, up_lt, out_free;

  logic sv_we, vs_we, key_we;
  logic [VID_W-1:0] sv_waddr, sv_wdata, vs_waddr, vs_wdata, key_waddr;
  logic [VID_W-1:0] sv_raddr, vs_raddr, key_raddr, sv_rdata, vs_rdata;
  logic [KEY_BITS-1:0] key_wdata, key_rdata;

  imh_ram #(.DEPTH(MAX_VERTICES), .AW(VID_W), .DW(VID_W)) u_slot_vertex (
    .clk, .we(sv_we), .waddr(sv_waddr), .wdata(sv_wdata), .raddr(sv_raddr),
    .rdata(sv_rdata));
  imh_ram #(.DEPTH(MAX_VERTICES), .AW(VID_W), .DW(VID_W)) u_vertex_slot (
    .clk, .we(vs_we), .waddr(vs_waddr), .wdata(vs_wdata), .raddr(vs_raddr),
    .rdata(vs_rdata));
  imh_ram #(.DEPTH(MAX_VERTICES), .AW(VID_W), .DW(KEY_BITS)) u_vertex_key (
    .clk, .we(key_we), .waddr(key_waddr), .wdata(key_wdata), .raddr(key_raddr),
    .rdata(key_rdata));

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign fill_sat = (32'(vcount) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(vcount);
  assign parent = (cur_slot - VID_W'(1)) >> 1;
  assign last = VID_W'(live - CNT_W'(1));
  assign l_ext = {1'b0, cur_slot, 1'b1};
  assign r_ext = l_ext + (VID_W+2)'(1);
  assign live_ext = (VID_W+2)'(live);
  assign l_in = l_ext < live_ext;
  assign r_in = r_ext < live_ext;
  assign lt_l = l_k < cur_k;
  assign min_k = lt_l ? l_k : cur_k;
  assign lt_r = r_in && (key_rdata < min_k);
  assign best_v = lt_r ? r_v : l_v;
  assign live_ok = (CNT_W'(cur_slot) < live) && (sv_rdata == vid);
  assign up_lt = cur_k < key_rdata;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (func)
            FN_RESTART: state_next = S_FILL;
            FN_EXTRACT: state_next = (live == '0) ? S_FIN : S_EX_A;
            default:    state_next = S_LK_SLOT;
          endcase
        end
      end
      S_FILL:    if (idx == fill_n) state_next = S_FIN;
      S_LK_SLOT: state_next = S_LK_CHK;
      S_LK_CHK: begin
        if (op == FN_DECREASE && live_ok && key <= old_key) state_next = S_UP_P;
        else state_next = S_FIN;
      end
      S_UP_P:    state_next = (cur_slot == '0) ? S_FIN : S_UP_K;
      S_UP_K:    state_next = S_UP_C;
      S_UP_C:    state_next = up_lt ? S_UP_P : S_FIN;
      S_EX_A:    state_next = S_EX_B;
      S_EX_B:    state_next = S_EX_C;
      S_EX_C:    state_next = S_DN_L;
      S_DN_L:    state_next = l_in ? S_DN_R : S_FIN;
      S_DN_R:    state_next = S_DN_K;
      S_DN_K:    state_next = S_DN_C;
      S_DN_C:    state_next = (lt_l || lt_r) ? S_DN_L : S_FIN;
      S_FIN:     if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    sv_we = 1'b0;
    sv_waddr = cur_slot;
    sv_wdata = cur_v;
    vs_we = 1'b0;
    vs_waddr = cur_v;
    vs_wdata = cur_slot;
    key_we = 1'b0;
    key_waddr = vid;
    key_wdata = key;
    sv_raddr = '0;
    vs_raddr = vid;
    key_raddr = vid;
    case (state)
      S_IDLE: begin
        vs_raddr = vertex_id;
        key_raddr = vertex_id;
      end
      S_FILL: begin
        if (idx != fill_n) begin
          sv_we = 1'b1;
          sv_waddr = VID_W'(idx);
          sv_wdata = VID_W'(idx);
          vs_we = 1'b1;
          vs_waddr = VID_W'(idx);
          vs_wdata = VID_W'(idx);
          key_we = 1'b1;
          key_waddr = VID_W'(idx);
          key_wdata = '1;
        end
      end
      S_LK_SLOT: sv_raddr = vs_rdata;
      S_LK_CHK:  key_we = (op == FN_DECREASE) && live_ok && (key <= old_key);
      S_UP_P: begin
        if (cur_slot == '0) begin
          sv_we = 1'b1;
          vs_we = 1'b1;
        end else begin
          sv_raddr = parent;
        end
      end
      S_UP_K: key_raddr = sv_rdata;
      S_UP_C: begin
        sv_we = 1'b1;
        vs_we = 1'b1;
        if (up_lt) begin
          sv_wdata = p_v;
          vs_waddr = p_v;
        end
      end
      S_EX_A: begin
        sv_raddr = last;
        key_raddr = sv_rdata;
      end
      S_EX_B: begin
        sv_we = 1'b1;
        sv_waddr = last;
        sv_wdata = res_vertex;
        vs_we = 1'b1;
        vs_waddr = res_vertex;
        vs_wdata = last;
        key_raddr = sv_rdata;
      end
      S_DN_L: begin
        if (l_in) begin
          sv_raddr = VID_W'(l_ext);
        end else begin
          sv_we = 1'b1;
          vs_we = 1'b1;
        end
      end
      S_DN_R: begin
        key_raddr = sv_rdata;
        sv_raddr = VID_W'(r_ext);
      end
      S_DN_K: key_raddr = sv_rdata;
      S_DN_C: begin
        sv_we = 1'b1;
        vs_we = 1'b1;
        if (lt_l || lt_r) begin
          sv_wdata = best_v;
          vs_waddr = best_v;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      live <= '0;
      vcount <= CFG_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        vcount <= cfg_data;
      end
      if (state == S_FILL && idx == fill_n) begin
        live <= fill_n;
      end
      if (state == S_EX_B) begin
        live <= live - CNT_W'(1);
      end
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op <= func;
        vid <= vertex_id;
        key <= new_key;
        fill_n <= fill_sat;
        idx <= '0;
        res_status <= (func == FN_EXTRACT && live == '0) ? ST_EMPTY : ST_OK;
        res_vertex <= '0;
        res_key <= '0;
        res_present <= 1'b0;
      end
      S_FILL: if (idx != fill_n) idx <= idx + CNT_W'(1);
      S_LK_SLOT: begin
        cur_slot <= vs_rdata;
        old_key <= key_rdata;
      end
      S_LK_CHK: begin
        res_present <= (op == FN_QUERY) && live_ok;
        if (op == FN_DECREASE && !live_ok) res_status <= ST_ABSENT;
        cur_v <= vid;
        cur_k <= key;
      end
      S_UP_K: p_v <= sv_rdata;
      S_UP_C: if (up_lt) cur_slot <= parent;
      S_EX_A: res_vertex <= sv_rdata;
      S_EX_B: begin
        res_key <= key_rdata;
        cur_v <= sv_rdata;
        cur_slot <= '0;
      end
      S_EX_C: cur_k <= key_rdata;
      S_DN_R: l_v <= sv_rdata;
      S_DN_K: begin
        l_k <= key_rdata;
        r_v <= sv_rdata;
      end
      S_DN_C: begin
        if (lt_r) cur_slot <= VID_W'(r_ext);
        else if (lt_l) cur_slot <= VID_W'(l_ext);
      end
      S_FIN: begin
        if (out_free) begin
          status <= res_status;
          out_vertex <= res_vertex;
          out_key <= res_key;
          present <= res_present;
          heap_count <= live;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/imh_checker.sv
// Port-level checker for the indexed min-heap, bound to the top level.
// Depends on imh_pkg and indexed_min_heap_assert.svh.
`include "indexed_min_heap_assert.svh"

module imh_checker #(
  parameter int MAX_VERTICES = 1024,
  parameter int KEY_BITS = 31,
  localparam int VID_W = $clog2(MAX_VERTICES),
  localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input imh_pkg::status_t    status,
  input logic [VID_W-1:0]    out_vertex,
  input logic [KEY_BITS-1:0] out_key,
  input logic                present,
  input logic [CNT_W-1:0]    heap_count
);
  import imh_pkg::*;

  `IMH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(heap_count))
  `IMH_ASSERT_NOW(a_empty, out_valid && status == ST_EMPTY, heap_count == '0 && out_vertex == '0)
  `IMH_ASSERT_NOW(a_absent, out_valid && status == ST_ABSENT, !present && out_key == '0)
  `IMH_ASSERT_NOW(a_count, out_valid, 32'(heap_count) <= MAX_VERTICES)

endmodule

bind indexed_min_heap imh_checker #(
  .MAX_VERTICES(MAX_VERTICES),
  .KEY_BITS(KEY_BITS)
) u_imh_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .status(status),
  .out_vertex(out_vertex),
  .out_key(out_key),
  .present(present),
  .heap_count(heap_count)
);
